/* design/sqd_pkg.sv */
package sqd_pkg;

  localparam int NUM_SERVERS = 3;
  localparam int QUEUE_DEPTH = 16;

  localparam int SVC_W  = 8;
  localparam int TOT_W  = 32;
  localparam int SRV_W  = $clog2(NUM_SERVERS);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DONE_W = $clog2(NUM_SERVERS + 1);
  localparam int SUM_W  = $clog2(NUM_SERVERS * QUEUE_DEPTH + 1);

  localparam logic [1:0] NO_ARRIVAL = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [SVC_W-1:0] service_minutes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       assigned_server;
    logic             rejected;
    logic [1:0]       completed_now;
    logic [TOT_W-1:0] finished_total;
    logic [TOT_W-1:0] wait_total;
    logic [TOT_W-1:0] accepted_total;
    logic [5:0]       waiting_now;
  } out_item_t;

  typedef struct packed {
    logic             tick;
    logic             push;
    logic [SVC_W-1:0] svc;
  } queue_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] load;
    logic [CNT_W-1:0] cnt_next;
    logic             fin;
  } queue_status_t;

  typedef struct packed {
    logic              tick;
    logic              accept;
    logic [DONE_W-1:0] done_n;
    logic [SUM_W-1:0]  wait_add;
  } stats_ctrl_t;

  typedef struct packed {
    logic [TOT_W-1:0] finished;
    logic [TOT_W-1:0] waited;
    logic [TOT_W-1:0] accepted;
  } totals_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

endpackage

/* design/sqd_ram.sv */
module sqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sqd_queue.sv */
module sqd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  sqd_pkg::queue_ctrl_t   ctrl,
  output sqd_pkg::queue_status_t status
);
  import sqd_pkg::*;

  logic [CNT_W-1:0] cnt, cnt_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [SVC_W-1:0] htime, htime_next;

  logic [CNT_W-1:0] load;
  logic [SVC_W-1:0] head_cur;
  logic [SVC_W-1:0] ram_q;
  logic [SVC_W-1:0] second;
  logic [SVC_W-1:0] byp_data;
  logic             byp_hit;
  logic [PTR_W-1:0] raddr;
  logic             active;
  logic             fin;

  assign load     = cnt + CNT_W'(ctrl.push);
  assign head_cur = (cnt != '0) ? htime : ctrl.svc;
  assign active   = (load != '0);
  assign fin      = active && (head_cur == '0);
  assign second   = byp_hit ? byp_data : ram_q;

  always_comb begin
    cnt_next   = cnt;
    head_next  = head;
    tail_next  = ctrl.push ? ring_next(tail) : tail;
    htime_next = htime;
    if (ctrl.tick) begin
      cnt_next = load - CNT_W'(fin);
      if (fin) begin
        head_next  = ring_next(head);
        htime_next = (cnt >= CNT_W'(2)) ? second : ctrl.svc;
      end else if (active) begin
        htime_next = head_cur - SVC_W'(1);
      end
    end
  end

  // prefetch the entry behind the next head
  assign raddr = ring_next(head_next);

  sqd_ram #(
    .WIDTH(SVC_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(tail),
    .wdata(ctrl.svc),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      head    <= '0;
      tail    <= '0;
      byp_hit <= 1'b0;
    end else begin
      cnt     <= cnt_next;
      head    <= head_next;
      tail    <= tail_next;
      byp_hit <= ctrl.push && (tail == raddr);
    end
    htime    <= htime_next;
    byp_data <= ctrl.svc;
  end

  assign status.cnt      = cnt;
  assign status.load     = load;
  assign status.cnt_next = cnt_next;
  assign status.fin      = ctrl.tick && fin;

endmodule

/* design/sqd_stats.sv */
module sqd_stats (
  input  logic                clk,
  input  logic                rst,
  input  sqd_pkg::stats_ctrl_t ctrl,
  output sqd_pkg::totals_t     totals_next
);
  import sqd_pkg::*;

  totals_t totals;

  always_comb begin
    totals_next = totals;
    if (ctrl.tick) begin
      totals_next.finished = sat_add(totals.finished, TOT_W'(ctrl.done_n));
      totals_next.waited   = sat_add(totals.waited, TOT_W'(ctrl.wait_add));
      totals_next.accepted = sat_add(totals.accepted, TOT_W'(ctrl.accept));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else begin
      totals <= totals_next;
    end
  end

endmodule

/* design/shortest_queue_dispatcher.sv */
// Join-shortest-queue dispatcher: each transfer in is one tick, optionally
// bringing a job that joins the least-loaded server queue (lowest index wins
// a tie, dropped and flagged when that queue is full); each tick then serves
// every queue head and one result transfer reports the choice and the
// running totals. One tick is taken every clock cycle while the output is
// not stalled by out_ready; an input transfer goes through the input register,
// then the result register. That rate is set by the single-pass update of all
// queues: each server keeps its head time in a register and prefetches the
// entry behind the head from its own job RAM, so a head may finish on every
// tick. Queues start empty after reset; no clearing pass is needed.
module shortest_queue_dispatcher (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sqd_pkg::out_item_t out_data
);
  import sqd_pkg::*;

  in_item_t      in_q;
  logic          in_valid_q;
  logic          advance;
  logic          arrive;
  logic          full;
  logic [SRV_W-1:0] best;
  logic [CNT_W-1:0] best_cnt;

  queue_ctrl_t   qctrl  [NUM_SERVERS];
  queue_status_t qstat  [NUM_SERVERS];
  stats_ctrl_t   sctrl;
  totals_t       totals_next;
  logic [SUM_W-1:0]  waiting;
  out_item_t     result;

  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;
  assign arrive   = advance && in_q.kind;

  always_comb begin
    best     = '0;
    best_cnt = qstat[0].cnt;
    for (int i = 1; i < NUM_SERVERS; i++) begin
      if (qstat[i].cnt < best_cnt) begin
        best     = SRV_W'(i);
        best_cnt = qstat[i].cnt;
      end
    end
  end

  assign full = (best_cnt >= CNT_W'(QUEUE_DEPTH));

  for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_queue
    assign qctrl[g].tick = advance;
    assign qctrl[g].push = arrive && !full && (best == SRV_W'(g));
    assign qctrl[g].svc  = in_q.service_minutes;

    sqd_queue u_queue (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (qctrl[g]),
      .status(qstat[g])
    );
  end

  always_comb begin
    sctrl.tick     = advance;
    sctrl.accept   = arrive && !full;
    sctrl.done_n   = '0;
    sctrl.wait_add = '0;
    waiting        = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      sctrl.done_n = sctrl.done_n + DONE_W'(qstat[i].fin);
      if (qstat[i].load > CNT_W'(1)) begin
        sctrl.wait_add = sctrl.wait_add + SUM_W'(qstat[i].load - CNT_W'(1));
      end
      if (qstat[i].cnt_next > CNT_W'(1)) begin
        waiting = waiting + SUM_W'(qstat[i].cnt_next - CNT_W'(1));
      end
    end
  end

  sqd_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sctrl),
    .totals_next(totals_next)
  );

  always_comb begin
    result.assigned_server = arrive ? 2'(best) : NO_ARRIVAL;
    result.rejected        = arrive && full;
    result.completed_now   = 2'(sctrl.done_n);
    result.finished_total  = totals_next.finished;
    result.wait_total      = totals_next.waited;
    result.accepted_total  = totals_next.accepted;
    result.waiting_now     = 6'(waiting);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_ready) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
